[design/sm3_hash_unit_assert.svh]
// Assertion macros for the SM3 hash unit.
`ifndef SM3_HASH_UNIT_ASSERT_SVH
`define SM3_HASH_UNIT_ASSERT_SVH

// same-cycle implication, on clock, off while reset
`define SM3_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sm3_hash_unit: same-cycle check failed");

// next-cycle implication, on clock, off while reset
`define SM3_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sm3_hash_unit: next-cycle check failed");

`endif

[design/sm3_pkg.sv]
package sm3_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] chain_type;   // index 0 is word A

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     push;
      logic     expand;
      word_type push_word;
   } win_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_ctrl_type;

   localparam int ROUNDS = 64;
   localparam int ROUND_W = $clog2(ROUNDS);
   localparam int DIGEST_WORDS = 8;
   localparam int OUT_IDX_W = $clog2(DIGEST_WORDS);
   localparam int BLOCK_WORDS = 16;
   localparam int FILL_W = $clog2(BLOCK_WORDS);

   localparam word_type T_LOW  = 32'h79CC4519;
   localparam word_type T_HIGH = 32'h7A879D8A;
   localparam word_type PAD_MARKER = 32'h80000000;

   localparam chain_type SM3_IV = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
   };

   function automatic word_type rotl32(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // round constant already rotated by the round index
   function automatic word_type round_const(input logic [ROUND_W-1:0] j);
      word_type t;
      t = (j < ROUND_W'(16)) ? T_LOW : T_HIGH;
      return rotl32(t, j[4:0]);
   endfunction

endpackage

[design/sm3_msg_window.sv]
module sm3_msg_window (
   input  logic                  clock,
   input  sm3_pkg::win_ctrl_type ctrl,
   output sm3_pkg::word_type     w_cur,
   output sm3_pkg::word_type     w_ahead
);
   import sm3_pkg::*;

   word_type win_ff [BLOCK_WORDS];
   word_type win_in [BLOCK_WORDS];
   word_type expanded;

   // w[j+16] from the sliding window of w[j..j+15]
   assign expanded = perm1(win_ff[0] ^ win_ff[7] ^ rotl32(win_ff[13], 5'd15))
                     ^ rotl32(win_ff[3], 5'd7) ^ win_ff[10];

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[BLOCK_WORDS - 1] = ctrl.push ? ctrl.push_word : expanded;
   end

   always_ff @(posedge clock) begin
      if (ctrl.push || ctrl.expand) begin
         win_ff <= win_in;
      end
   end

   assign w_cur   = win_ff[0];
   assign w_ahead = win_ff[4];

endmodule

[design/sm3_round.sv]
module sm3_round (
   input  logic                           clock,
   input  sm3_pkg::round_ctrl_type        ctrl,
   input  logic [sm3_pkg::ROUND_W-1:0]    round_idx,
   input  sm3_pkg::word_type              w_cur,
   input  sm3_pkg::word_type              w_ahead,
   input  sm3_pkg::chain_type             chain,
   output sm3_pkg::chain_type             v_next
);
   import sm3_pkg::*;

   chain_type v_ff;
   word_type  a12, ss1, ss2, ff_val, gg_val, tt1, tt2;

   always_comb begin
      a12 = rotl32(v_ff[0], 5'd12);
      ss1 = rotl32(a12 + v_ff[4] + round_const(round_idx), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_idx < ROUND_W'(16)) begin
         ff_val = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         gg_val = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ff_val = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         gg_val = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = ff_val + v_ff[3] + ss2 + (w_cur ^ w_ahead);
      tt2 = gg_val + v_ff[7] + ss1 + w_cur;
      v_next[0] = tt1;
      v_next[1] = v_ff[0];
      v_next[2] = rotl32(v_ff[1], 5'd9);
      v_next[3] = v_ff[2];
      v_next[4] = perm0(tt2);
      v_next[5] = v_ff[4];
      v_next[6] = rotl32(v_ff[5], 5'd19);
      v_next[7] = v_ff[6];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         v_ff <= chain;
      end else if (ctrl.step) begin
         v_ff <= v_next;
      end
   end

endmodule

[design/sm3_hash_unit.sv]
// SM3 hash unit: one message word per item, digest as eight result items.
// A word that does not complete a block is just stored; the 16th word of a block
// starts the compression, one round per cycle in one shared round unit.
// No new word is taken while a block is being compressed.
// Last word: the padding words, one or two compressions, then 8 digest items.
// Synchronous active-high reset loads the initial vector and clears length and fill.
`include "sm3_hash_unit_assert.svh"

module sm3_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // digest_last
);
   import sm3_pkg::*;

   state_type            state_ff, state_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [63:0]          bitlen_ff, bitlen_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [OUT_IDX_W-1:0] out_idx_ff, out_idx_in;
   logic                 pad_ff, pad_in;
   logic                 marker_ff, marker_in;
   logic                 hi_ok_ff, hi_ok_in;
   logic                 final_ff, final_in;
   chain_type            chain_ff, chain_in;

   win_ctrl_type   win_ctrl;
   round_ctrl_type rnd_ctrl;
   word_type       w_cur, w_ahead;
   chain_type      v_next;

   logic      req_accept, rsp_accept, last_accept, marker_push, comp_done, out_done;
   logic [2:0] nb_eff;
   word_type  msg_word, last_word_val, pad_word;

   assign msg_word   = req_tdata[31:0];
   assign nb_eff     = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign last_accept = req_accept && req_tlast;
   assign comp_done  = (state_ff == ST_COMP) && (round_ff == ROUND_W'(ROUNDS - 1));
   assign out_done   = rsp_accept && rsp_tlast;

   always_comb begin
      case (nb_eff[1:0])
         2'd1:    last_word_val = {msg_word[31:24], 24'h800000};
         2'd2:    last_word_val = {msg_word[31:16], 16'h8000};
         2'd3:    last_word_val = {msg_word[31:8], 8'h80};
         default: last_word_val = PAD_MARKER;
      endcase
   end

   always_comb begin
      if (marker_ff) begin
         pad_word = PAD_MARKER;
      end else if (hi_ok_ff && fill_ff == FILL_W'(BLOCK_WORDS - 2)) begin
         pad_word = bitlen_ff[63:32];
      end else if (hi_ok_ff && fill_ff == FILL_W'(BLOCK_WORDS - 1)) begin
         pad_word = bitlen_ff[31:0];
      end else begin
         pad_word = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (fill_ff == FILL_W'(BLOCK_WORDS - 1)) begin
                  state_in = ST_COMP;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == FILL_W'(BLOCK_WORDS - 1)) begin
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            if (comp_done) begin
               if (final_ff) begin
                  state_in = ST_OUT;
               end else if (pad_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (out_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready         = 1'b0;
      rsp_tvalid         = 1'b0;
      win_ctrl.push      = 1'b0;
      win_ctrl.expand    = 1'b0;
      win_ctrl.push_word = msg_word;
      marker_push        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // always ready here, so tvalid alone marks an accepted item
            req_tready    = 1'b1;
            win_ctrl.push = req_tvalid;
            if (req_tlast && nb_eff != 3'd4) begin
               win_ctrl.push_word = last_word_val;
               marker_push        = req_tvalid;
            end
         end
         ST_PAD: begin
            win_ctrl.push      = 1'b1;
            win_ctrl.push_word = pad_word;
            marker_push        = marker_ff;
         end
         ST_COMP: begin
            win_ctrl.expand = 1'b1;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      rnd_ctrl.load = win_ctrl.push && (fill_ff == FILL_W'(BLOCK_WORDS - 1));
      rnd_ctrl.step = (state_ff == ST_COMP);
   end

   assign rsp_tdata = chain_ff[0];
   assign rsp_tlast = (out_idx_ff == OUT_IDX_W'(DIGEST_WORDS - 1));

   always_comb begin
      fill_in    = win_ctrl.push ? fill_ff + FILL_W'(1) : fill_ff;
      round_in   = rnd_ctrl.step ? round_ff + ROUND_W'(1) : '0;
      out_idx_in = rsp_accept ? out_idx_ff + OUT_IDX_W'(1) : out_idx_ff;

      bitlen_in = bitlen_ff;
      if (req_accept) begin
         bitlen_in = req_tlast ? bitlen_ff + {58'd0, nb_eff, 3'd0} : bitlen_ff + 64'd32;
      end else if (out_done) begin
         bitlen_in = '0;
      end

      pad_in    = pad_ff;
      marker_in = marker_ff;
      hi_ok_in  = hi_ok_ff;
      final_in  = final_ff;
      if (last_accept) begin
         pad_in    = 1'b1;
         marker_in = (nb_eff == 3'd4);
      end
      if (state_ff == ST_PAD && marker_ff) begin
         marker_in = 1'b0;
      end
      // length words only go where a padding run reaches the block's last two slots
      if (marker_push && fill_ff != FILL_W'(BLOCK_WORDS - 2)) begin
         hi_ok_in = 1'b1;
      end
      if (state_ff == ST_PAD && !marker_ff && fill_ff == FILL_W'(BLOCK_WORDS - 1)) begin
         if (hi_ok_ff) begin
            final_in = 1'b1;
         end else begin
            hi_ok_in = 1'b1;
         end
      end
      if (out_done) begin
         pad_in   = 1'b0;
         hi_ok_in = 1'b0;
         final_in = 1'b0;
      end

      chain_in = chain_ff;
      if (comp_done) begin
         chain_in = chain_ff ^ v_next;
      end else if (out_done) begin
         chain_in = SM3_IV;
      end else if (rsp_accept) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            chain_in[i] = chain_ff[i + 1];
         end
         chain_in[DIGEST_WORDS - 1] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         bitlen_ff  <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
         pad_ff     <= 1'b0;
         marker_ff  <= 1'b0;
         hi_ok_ff   <= 1'b0;
         final_ff   <= 1'b0;
         chain_ff   <= SM3_IV;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bitlen_ff  <= bitlen_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         pad_ff     <= pad_in;
         marker_ff  <= marker_in;
         hi_ok_ff   <= hi_ok_in;
         final_ff   <= final_in;
         chain_ff   <= chain_in;
      end
   end

   sm3_msg_window u_window (
      .clock   (clock),
      .ctrl    (win_ctrl),
      .w_cur   (w_cur),
      .w_ahead (w_ahead)
   );

   sm3_round u_round (
      .clock     (clock),
      .ctrl      (rnd_ctrl),
      .round_idx (round_ff),
      .w_cur     (w_cur),
      .w_ahead   (w_ahead),
      .chain     (chain_ff),
      .v_next    (v_next)
   );

   `SM3_ASSERT_NOW(a_no_input_while_output, rsp_tvalid, !req_tready)
   `SM3_ASSERT_NEXT(a_block_starts_round0, rnd_ctrl.load, state_ff == ST_COMP && round_ff == '0)
   `SM3_ASSERT_NEXT(a_comp_ends, comp_done, state_ff != ST_COMP)
   `SM3_ASSERT_NEXT(a_clean_after_digest, out_done, state_ff == ST_IDLE && bitlen_ff == '0)
   `SM3_ASSERT_NEXT(a_empty_after_digest, out_done, fill_ff == '0 && !pad_ff)

endmodule
